// ----- src/rc4sc_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared constants, codes and controller/datapath interface types of the
// RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int KEY_MAX_BYTES = 256;
	localparam int PERM_SIZE     = 256;
	localparam int BYTE_W        = 8;
	localparam int PERM_AW       = 8;
	localparam int KEY_AW        = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
	localparam int KLEN_W        = 9;

	localparam logic [KLEN_W-1:0] KEY_MAX_LEN = KLEN_W'(KEY_MAX_BYTES);

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SCHED = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DATA  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_NOKEY = 2'd2;

	// permutation table address source
	typedef enum logic [2:0] {
		A_N,      // schedule counter
		A_INEXT,  // i + 1
		A_JKSA,   // j + S[n] + key
		A_JGEN,   // j + S[i]
		A_JQ,     // registered j
		A_IQ,     // registered i
		A_T       // S[i] + S[j]
	} addr_sel_t;

	// permutation table write data source
	typedef enum logic [1:0] {
		W_N,
		W_RD,
		W_SI
	} wd_sel_t;

	typedef enum logic [1:0] {
		J_HOLD,
		J_CLR,
		J_KSA,
		J_GEN
	} j_op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_DATA,
		EMIT_DONE,
		EMIT_NOKEY
	} emit_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      perm_we;
		wd_sel_t   wd_sel;
		logic      key_we;
		logic      ld_len;
		logic      clr_cnt;
		logic      step_n;
		logic      step_key;
		logic      ld_si;
		logic      ld_sj;
		j_op_t     j_op;
		logic      inc_i;
		logic      clr_gen;
		logic      set_keyed;
		logic      ld_data;
		emit_t     emit;
	} dp_ctrl_t;

	typedef struct packed {
		logic keyed;
		logic n_last;
	} dp_stat_t;

endpackage

// ----- src/rc4sc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4sc_ctrl
// Sequencer for the RC4 core: table fill, key scheduling and keystream
// generation steps over the single-port permutation table.
// ----------------------------------------------------------------------------
module rc4sc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          cmd,
	input  rc4sc_pkg::dp_stat_t stat,
	output rc4sc_pkg::dp_ctrl_t ctl,
	output logic                busy
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_FILL  = 11'b000_0000_0010,
		S_KA    = 11'b000_0000_0100,
		S_KB    = 11'b000_0000_1000,
		S_KC    = 11'b000_0001_0000,
		S_KD    = 11'b000_0010_0000,
		S_SDONE = 11'b000_0100_0000,
		S_GB    = 11'b000_1000_0000,
		S_GC    = 11'b001_0000_0000,
		S_GD    = 11'b010_0000_0000,
		S_GE    = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.addr_sel = rc4sc_pkg::A_N;
		ctl.wd_sel   = rc4sc_pkg::W_N;
		ctl.j_op     = rc4sc_pkg::J_HOLD;
		ctl.emit     = rc4sc_pkg::EMIT_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						rc4sc_pkg::CMD_LOAD: begin
							ctl.key_we = 1'b1;
						end
						rc4sc_pkg::CMD_SCHED: begin
							ctl.ld_len  = 1'b1;
							ctl.clr_cnt = 1'b1;
							ctl.j_op    = rc4sc_pkg::J_CLR;
							state_d     = S_FILL;
						end
						rc4sc_pkg::CMD_DATA: begin
							if (stat.keyed) begin
								// fetch S[i+1] on the transfer edge
								ctl.addr_sel = rc4sc_pkg::A_INEXT;
								ctl.inc_i    = 1'b1;
								ctl.ld_data  = 1'b1;
								state_d      = S_GB;
							end else begin
								ctl.emit = rc4sc_pkg::EMIT_NOKEY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_FILL: begin
				ctl.perm_we  = 1'b1;
				ctl.addr_sel = rc4sc_pkg::A_N;
				ctl.wd_sel   = rc4sc_pkg::W_N;
				ctl.step_n   = 1'b1;
				if (stat.n_last) begin
					state_d = S_KA;
				end
			end
			S_KA: begin
				ctl.addr_sel = rc4sc_pkg::A_N;
				state_d      = S_KB;
			end
			S_KB: begin
				ctl.addr_sel = rc4sc_pkg::A_JKSA;
				ctl.ld_si    = 1'b1;
				ctl.j_op     = rc4sc_pkg::J_KSA;
				state_d      = S_KC;
			end
			S_KC: begin
				ctl.perm_we  = 1'b1;
				ctl.addr_sel = rc4sc_pkg::A_N;
				ctl.wd_sel   = rc4sc_pkg::W_RD;
				state_d      = S_KD;
			end
			S_KD: begin
				ctl.perm_we  = 1'b1;
				ctl.addr_sel = rc4sc_pkg::A_JQ;
				ctl.wd_sel   = rc4sc_pkg::W_SI;
				ctl.step_n   = 1'b1;
				ctl.step_key = 1'b1;
				state_d      = stat.n_last ? S_SDONE : S_KA;
			end
			S_SDONE: begin
				ctl.clr_gen   = 1'b1;
				ctl.set_keyed = 1'b1;
				ctl.emit      = rc4sc_pkg::EMIT_DONE;
				state_d       = S_IDLE;
			end
			S_GB: begin
				ctl.addr_sel = rc4sc_pkg::A_JGEN;
				ctl.ld_si    = 1'b1;
				ctl.j_op     = rc4sc_pkg::J_GEN;
				state_d      = S_GC;
			end
			S_GC: begin
				ctl.perm_we  = 1'b1;
				ctl.addr_sel = rc4sc_pkg::A_IQ;
				ctl.wd_sel   = rc4sc_pkg::W_RD;
				ctl.ld_sj    = 1'b1;
				state_d      = S_GD;
			end
			S_GD: begin
				ctl.addr_sel = rc4sc_pkg::A_T;
				state_d      = S_GE;
			end
			S_GE: begin
				ctl.perm_we  = 1'b1;
				ctl.addr_sel = rc4sc_pkg::A_JQ;
				ctl.wd_sel   = rc4sc_pkg::W_SI;
				ctl.emit     = rc4sc_pkg::EMIT_DATA;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/rc4sc_datapath.sv -----
// ----------------------------------------------------------------------------
// rc4sc_datapath
// Permutation table and key store memories, index registers, adders and
// the registered result outputs of the RC4 core.
// ----------------------------------------------------------------------------
module rc4sc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rc4sc_pkg::dp_ctrl_t              ctl,
	output rc4sc_pkg::dp_stat_t              stat,
	input  logic [rc4sc_pkg::BYTE_W-1:0]     key_byte,
	input  logic [rc4sc_pkg::BYTE_W-1:0]     key_index,
	input  logic [rc4sc_pkg::KLEN_W-1:0]     key_len,
	input  logic [rc4sc_pkg::BYTE_W-1:0]     data_byte,
	output logic                             strobe,
	output logic [rc4sc_pkg::BYTE_W-1:0]     out_byte,
	output logic [1:0]                       status
);

	logic [rc4sc_pkg::BYTE_W-1:0] perm_mem [rc4sc_pkg::PERM_SIZE];
	logic [rc4sc_pkg::BYTE_W-1:0] key_mem  [rc4sc_pkg::KEY_MAX_BYTES];

	logic [rc4sc_pkg::BYTE_W-1:0]  perm_rd_q, key_rd_q;
	logic [rc4sc_pkg::BYTE_W-1:0]  si_q, sj_q, i_q, j_q, data_q;
	logic [rc4sc_pkg::PERM_AW-1:0] n_q;
	logic [rc4sc_pkg::KLEN_W-1:0]  k_q, len_q, len_eff, k_inc;
	logic                          keyed_q;
	logic                          strobe_q;
	logic [rc4sc_pkg::BYTE_W-1:0]  out_byte_q;
	logic [1:0]                    status_q;

	logic [rc4sc_pkg::BYTE_W-1:0]  j_ksa, j_gen, i_next, t_idx, ks, wdata;
	logic [rc4sc_pkg::PERM_AW-1:0] addr;
	logic                          key_in_range;

	assign j_ksa  = j_q + perm_rd_q + key_rd_q;
	assign j_gen  = j_q + perm_rd_q;
	assign i_next = i_q + 1'b1;
	assign t_idx  = si_q + sj_q;
	// S[j] is written only after the final lookup; forward when t hits j
	assign ks     = (t_idx == j_q) ? si_q : perm_rd_q;
	assign k_inc  = k_q + 1'b1;

	always_comb begin
		case (ctl.addr_sel)
			rc4sc_pkg::A_N:     addr = n_q;
			rc4sc_pkg::A_INEXT: addr = i_next;
			rc4sc_pkg::A_JKSA:  addr = j_ksa;
			rc4sc_pkg::A_JGEN:  addr = j_gen;
			rc4sc_pkg::A_JQ:    addr = j_q;
			rc4sc_pkg::A_IQ:    addr = i_q;
			rc4sc_pkg::A_T:     addr = t_idx;
			default:            addr = n_q;
		endcase
	end

	always_comb begin
		case (ctl.wd_sel)
			rc4sc_pkg::W_N:  wdata = n_q;
			rc4sc_pkg::W_RD: wdata = perm_rd_q;
			rc4sc_pkg::W_SI: wdata = si_q;
			default:         wdata = n_q;
		endcase
	end

	always_comb begin
		if (key_len == '0) begin
			len_eff = rc4sc_pkg::KLEN_W'(1);
		end else if (key_len > rc4sc_pkg::KEY_MAX_LEN) begin
			len_eff = rc4sc_pkg::KEY_MAX_LEN;
		end else begin
			len_eff = key_len;
		end
	end

	assign key_in_range = ({1'b0, key_index} < rc4sc_pkg::KEY_MAX_LEN);

	// single-port permutation table, registered read
	always_ff @(posedge clk) begin
		if (ctl.perm_we) begin
			perm_mem[addr] <= wdata;
		end else begin
			perm_rd_q <= perm_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.key_we && key_in_range) begin
			key_mem[key_index[rc4sc_pkg::KEY_AW-1:0]] <= key_byte;
		end
		key_rd_q <= key_mem[k_q[rc4sc_pkg::KEY_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_si) begin
			si_q <= perm_rd_q;
		end
		if (ctl.ld_sj) begin
			sj_q <= perm_rd_q;
		end
		if (ctl.ld_data) begin
			data_q <= data_byte;
		end
		if (ctl.ld_len) begin
			len_q <= len_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			keyed_q <= 1'b0;
		end else begin
			if (ctl.clr_cnt) begin
				n_q <= '0;
				k_q <= '0;
			end else begin
				if (ctl.step_n) begin
					n_q <= n_q + 1'b1;
				end
				if (ctl.step_key) begin
					k_q <= (k_inc == len_q) ? '0 : k_inc;
				end
			end
			if (ctl.clr_gen) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (ctl.inc_i) begin
					i_q <= i_next;
				end
				case (ctl.j_op)
					rc4sc_pkg::J_CLR: j_q <= '0;
					rc4sc_pkg::J_KSA: j_q <= j_ksa;
					rc4sc_pkg::J_GEN: j_q <= j_gen;
					default:          j_q <= j_q;
				endcase
			end
			if (ctl.set_keyed) begin
				keyed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (ctl.emit != rc4sc_pkg::EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.emit)
			rc4sc_pkg::EMIT_DATA: begin
				out_byte_q <= data_q ^ ks;
				status_q   <= rc4sc_pkg::ST_DATA;
			end
			rc4sc_pkg::EMIT_DONE: begin
				out_byte_q <= '0;
				status_q   <= rc4sc_pkg::ST_DONE;
			end
			rc4sc_pkg::EMIT_NOKEY: begin
				out_byte_q <= '0;
				status_q   <= rc4sc_pkg::ST_NOKEY;
			end
			default: begin
			end
		endcase
	end

	assign stat.keyed  = keyed_q;
	assign stat.n_last = &n_q;

	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign status   = status_q;

endmodule

// ----- src/rc4_stream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 cipher engine: key store loading, key scheduling and byte-wise
// keystream XOR.
//
//  channel  | ports                                     | transfer
//  ---------+-------------------------------------------+------------------
//  command  | cmd key_byte key_index key_len data_byte  | start && !busy
//  result   | out_byte status                           | strobe, 1 cycle
//
//  Key load: no busy period, no result. Not-keyed data: result in the next
//  cycle. Data byte: read/read/write/read/write on the single-port table,
//  busy in states GB to GE, result in the cycle after. Schedule: busy in the
//  table fill, then KA, KB, KC, KD per table entry and a done state, result
//  in the cycle after. Reset clears indices and the keyed flag; table and key
//  store are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   cmd,
	input  logic [rc4sc_pkg::BYTE_W-1:0] key_byte,
	input  logic [rc4sc_pkg::BYTE_W-1:0] key_index,
	input  logic [rc4sc_pkg::KLEN_W-1:0] key_len,
	input  logic [rc4sc_pkg::BYTE_W-1:0] data_byte,
	output logic                         strobe,
	output logic [rc4sc_pkg::BYTE_W-1:0] out_byte,
	output logic [1:0]                   status
);

	rc4sc_pkg::dp_ctrl_t ctl;
	rc4sc_pkg::dp_stat_t stat;

	rc4sc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	rc4sc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.key_byte   (key_byte),
		.key_index  (key_index),
		.key_len    (key_len),
		.data_byte  (data_byte),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.status     (status)
	);

endmodule

// ----- src/rc4sc_checker.sv -----
// ----------------------------------------------------------------------------
// rc4sc_checker
// Port-level checks of the RC4 core, bound to the top level.
// ----------------------------------------------------------------------------
module rc4sc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   cmd,
	input logic                         strobe,
	input logic [rc4sc_pkg::BYTE_W-1:0] out_byte,
	input logic [1:0]                   status
);

	// a data transfer either starts generation or reports not keyed
	a_data_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == rc4sc_pkg::CMD_DATA |=> busy || strobe)
		else $error("data transfer got neither busy nor result");

	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == rc4sc_pkg::CMD_SCHED |=> busy)
		else $error("schedule transfer did not raise busy");

	// every end of a busy period delivers its result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe)
		else $error("busy dropped without a result");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != rc4sc_pkg::ST_DATA |-> out_byte == '0)
		else $error("non-data result with nonzero byte");

endmodule

bind rc4_stream_cipher_core rc4sc_checker u_rc4sc_checker (.*);

// ----- dv/rc4_stream_cipher_core_tb.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core testbench
// Drives key loads, key schedules, cipher bytes and unused commands through
// the start/busy command port and checks every strobed result against an
// in-bench RC4 keystream tracker. A directed opening covers the corner cases.
// A random phase then mixes full key/schedule/data sequences with noise and
// random sender gaps.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          N_ITEMS     = 1000;
	localparam int          TAIL_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct {
		logic [rc4sc_pkg::BYTE_W-1:0] out_byte;
		logic [1:0]                   status;
	} cipher_result_t;

	class rc4_keystream_tracker;
		logic [rc4sc_pkg::BYTE_W-1:0] sbox [rc4sc_pkg::PERM_SIZE];
		logic [rc4sc_pkg::BYTE_W-1:0] key_mem [rc4sc_pkg::KEY_MAX_BYTES];
		logic [rc4sc_pkg::BYTE_W-1:0] idx_i;
		logic [rc4sc_pkg::BYTE_W-1:0] idx_j;
		logic                         keyed;
		cipher_result_t               pending_results [$];
		int                           errors;

		function new();
			idx_i  = '0;
			idx_j  = '0;
			keyed  = 1'b0;
			errors = 0;
		endfunction

		function void swap_entries(logic [rc4sc_pkg::BYTE_W-1:0] a,
				logic [rc4sc_pkg::BYTE_W-1:0] b);
			logic [rc4sc_pkg::BYTE_W-1:0] t;
			t       = sbox[a];
			sbox[a] = sbox[b];
			sbox[b] = t;
		endfunction

		function void schedule_perm(logic [rc4sc_pkg::KLEN_W-1:0] klen);
			int                           len;
			logic [rc4sc_pkg::BYTE_W-1:0] j;
			len = (klen == 0) ? 1
					: ((klen > rc4sc_pkg::KEY_MAX_LEN) ? rc4sc_pkg::KEY_MAX_BYTES
					: int'(klen));
			for (int n = 0; n < rc4sc_pkg::PERM_SIZE; n++)
				sbox[n] = rc4sc_pkg::BYTE_W'(n);
			j = '0;
			for (int n = 0; n < rc4sc_pkg::PERM_SIZE; n++) begin
				j = j + sbox[n] + key_mem[n % len];
				swap_entries(rc4sc_pkg::BYTE_W'(n), j);
			end
			idx_i = '0;
			idx_j = '0;
			keyed = 1'b1;
		endfunction

		function logic [rc4sc_pkg::BYTE_W-1:0] next_keystream();
			logic [rc4sc_pkg::BYTE_W-1:0] t;
			idx_i = idx_i + 1'b1;
			idx_j = idx_j + sbox[idx_i];
			swap_entries(idx_i, idx_j);
			t = sbox[idx_i] + sbox[idx_j];
			return sbox[t];
		endfunction

		function void note_transfer(logic [1:0] c, logic [rc4sc_pkg::BYTE_W-1:0] kb,
				logic [rc4sc_pkg::BYTE_W-1:0] ki, logic [rc4sc_pkg::KLEN_W-1:0] kl,
				logic [rc4sc_pkg::BYTE_W-1:0] db);
			cipher_result_t r;
			case (c)
				rc4sc_pkg::CMD_LOAD: begin
					key_mem[ki] = kb;
				end
				rc4sc_pkg::CMD_SCHED: begin
					schedule_perm(kl);
					r.out_byte = '0;
					r.status   = rc4sc_pkg::ST_DONE;
					pending_results.push_back(r);
				end
				rc4sc_pkg::CMD_DATA: begin
					if (!keyed) begin
						r.out_byte = '0;
						r.status   = rc4sc_pkg::ST_NOKEY;
					end else begin
						r.out_byte = db ^ next_keystream();
						r.status   = rc4sc_pkg::ST_DATA;
					end
					pending_results.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [rc4sc_pkg::BYTE_W-1:0] ob, logic [1:0] st);
			cipher_result_t r;
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_byte %02h status %0d", ob, st);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			if (ob !== r.out_byte) begin
				$error("out_byte mismatch: expected %02h, actual %02h", r.out_byte, ob);
				errors++;
			end
			if (st !== r.status) begin
				$error("status mismatch: expected %0d, actual %0d", r.status, st);
				errors++;
			end
		endfunction
	endclass

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         start      = 1'b0;
	logic [1:0]                   cmd        = rc4sc_pkg::CMD_LOAD;
	logic [rc4sc_pkg::BYTE_W-1:0] key_byte   = '0;
	logic [rc4sc_pkg::BYTE_W-1:0] key_index  = '0;
	logic [rc4sc_pkg::KLEN_W-1:0] key_len    = '0;
	logic [rc4sc_pkg::BYTE_W-1:0] data_byte  = '0;
	logic                         busy;
	logic                         strobe;
	logic [rc4sc_pkg::BYTE_W-1:0] out_byte;
	logic [1:0]                   status;

	rc4_keystream_tracker tracker;
	bit                   key_written [rc4sc_pkg::KEY_MAX_BYTES];
	bit                   no_gaps;
	int                   items_sent;
	int unsigned          cycle_count;

	rc4_stream_cipher_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.key_byte   (key_byte),
		.key_index  (key_index),
		.key_len    (key_len),
		.data_byte  (data_byte),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.status     (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rc4_stream_cipher_core test failed");
			$finish;
		end
	end

	// results cannot be stalled: sample every strobed cycle
	always @(posedge clk) begin
		if (arst_n && strobe)
			tracker.check_result(out_byte, status);
	end

	function automatic logic [rc4sc_pkg::BYTE_W-1:0] rnd8();
		return rc4sc_pkg::BYTE_W'($urandom);
	endfunction

	function automatic logic [rc4sc_pkg::KLEN_W-1:0] rnd9();
		return rc4sc_pkg::KLEN_W'($urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// longest run of written key bytes starting at index 0
	function automatic int key_prefix();
		int n;
		n = 0;
		while (n < rc4sc_pkg::KEY_MAX_BYTES && key_written[n])
			n++;
		return n;
	endfunction

	function automatic int pick_key_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return rc4sc_pkg::KEY_MAX_BYTES;
		if (r < 15)
			return $urandom_range(17, 64);
		return $urandom_range(1, 16);
	endfunction

	// zero means one, anything past the maximum saturates
	function automatic logic [rc4sc_pkg::KLEN_W-1:0] encode_len(int eff);
		if (eff == 1 && $urandom_range(0, 2) == 0)
			return '0;
		if (eff == rc4sc_pkg::KEY_MAX_BYTES && $urandom_range(0, 1) == 1)
			return rc4sc_pkg::KLEN_W'($urandom_range(rc4sc_pkg::KEY_MAX_BYTES + 1, 511));
		return rc4sc_pkg::KLEN_W'(eff);
	endfunction

	task automatic send_cmd(input logic [1:0] c, input logic [rc4sc_pkg::BYTE_W-1:0] kb,
			input logic [rc4sc_pkg::BYTE_W-1:0] ki, input logic [rc4sc_pkg::KLEN_W-1:0] kl,
			input logic [rc4sc_pkg::BYTE_W-1:0] db);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		cmd        <= c;
		key_byte   <= kb;
		key_index  <= ki;
		key_len    <= kl;
		data_byte  <= db;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_transfer(c, kb, ki, kl, db);
		if (c == rc4sc_pkg::CMD_LOAD)
			key_written[ki] = 1'b1;
		if (c != CMD_UNUSED)
			items_sent++;
	endtask

	initial begin
		int                           klen_eff;
		int                           seq;
		logic [1:0]                   op;
		logic [rc4sc_pkg::KLEN_W-1:0] kl;

		tracker = new();
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not keyed yet: both data bytes answer with the error status
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'h00);
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'hFF);
		send_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 9'h1FF, 8'hFF);
		send_cmd(rc4sc_pkg::CMD_LOAD, 8'h00, 8'd0, rnd9(), rnd8());
		send_cmd(rc4sc_pkg::CMD_LOAD, 8'hFF, 8'd1, rnd9(), rnd8());
		send_cmd(rc4sc_pkg::CMD_LOAD, 8'h80, 8'd2, rnd9(), rnd8());
		send_cmd(rc4sc_pkg::CMD_LOAD, 8'h5A, 8'd255, rnd9(), rnd8());
		send_cmd(rc4sc_pkg::CMD_SCHED, rnd8(), rnd8(), 9'd0, rnd8());
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'h00);
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'hFF);
		send_cmd(rc4sc_pkg::CMD_SCHED, rnd8(), rnd8(), 9'd3, rnd8());
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'h00);
		send_cmd(CMD_UNUSED, 8'h00, 8'h00, 9'h000, 8'h00);
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'hFF);
		send_cmd(rc4sc_pkg::CMD_SCHED, rnd8(), rnd8(), 9'd1, rnd8());
		send_cmd(rc4sc_pkg::CMD_SCHED, rnd8(), rnd8(), 9'd2, rnd8());
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'h55);
		send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), 8'hAA);

		seq = 0;
		while (items_sent < N_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (seq == 0 || $urandom_range(0, 9) < 7) begin
				// key load, schedule, then a burst of cipher bytes
				klen_eff = (seq == 0) ? rc4sc_pkg::KEY_MAX_BYTES : pick_key_len();
				for (int k = 0; k < klen_eff; k++)
					send_cmd(rc4sc_pkg::CMD_LOAD, rnd8(), rc4sc_pkg::BYTE_W'(k), rnd9(),
							rnd8());
				kl = (seq == 0)
						? rc4sc_pkg::KLEN_W'($urandom_range(rc4sc_pkg::KEY_MAX_BYTES + 1, 511))
						: encode_len(klen_eff);
				send_cmd(rc4sc_pkg::CMD_SCHED, rnd8(), rnd8(), kl, rnd8());
				repeat ($urandom_range(1, 40))
					send_cmd(rc4sc_pkg::CMD_DATA, rnd8(), rnd8(), rnd9(), rnd8());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					op = 2'($urandom_range(0, 3));
					kl = (op == rc4sc_pkg::CMD_SCHED)
							? encode_len($urandom_range(1, key_prefix()))
							: rnd9();
					send_cmd(op, rnd8(), rnd8(), kl, rnd8());
				end
			end
			seq++;
		end
		start <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("rc4_stream_cipher_core test passed");
		else
			$display("rc4_stream_cipher_core test failed");
		$finish;
	end

endmodule
